// File: rtl/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// shared constants and register codes of the pair proximity interval detector
// ----------------------------------------------------------------------------
package ppid_pkg;

	localparam int ID_BITS_DEF      = 16;
	localparam int TIME_BITS_DEF    = 32;
	localparam int POS_BITS_DEF     = 24;
	localparam int LIMIT_BITS       = 52;
	localparam int CFG_INDEX_BITS   = 8;
	localparam int QUEUE_DEPTH_LOG2 = 2;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FIRST_ID   = 8'd0,
		REG_SECOND_ID  = 8'd1,
		REG_DIST_LIMIT = 8'd2
	} cfg_reg_t;

endpackage

// File: rtl/pair_proximity_interval_detector_core.sv
// ----------------------------------------------------------------------------
// pair_proximity_interval_detector_core
// reports time intervals during which two tracked objects stay close
// ----------------------------------------------------------------------------
// Takes one position sample per cycle while the queue has room and reports
// an interval [start, end] when two tracked objects move apart after having
// been within the squared distance limit. The front part updates per-object
// time and position registers in the accept cycle and queues a distance
// request; the back part squares the three coordinate differences in one
// stage and does the sum, threshold compare and interval bookkeeping in the
// next. A result passes the queue, square stage and output register, and the
// block sustains one sample per cycle as long as results are taken. The
// request queue (four entries) buffers requests during output stalls.
// Configuration writes are always ready and take effect in the next cycle.
// ----------------------------------------------------------------------------
module pair_proximity_interval_detector_core #(
	parameter int ID_BITS   = ppid_pkg::ID_BITS_DEF,
	parameter int TIME_BITS = ppid_pkg::TIME_BITS_DEF,
	parameter int POS_BITS  = ppid_pkg::POS_BITS_DEF,
	localparam int IN_FIELD_BITS = ID_BITS + TIME_BITS + 3 * POS_BITS,
	localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_BITS = ((2 * TIME_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample request
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// object_id, sample_time, pos_x, pos_y, pos_z
	input  logic [IN_DATA_BITS-1:0]             s_tdata,
	// interval result
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// interval_start, interval_end
	output logic [OUT_DATA_BITS-1:0]            m_tdata,
	// register write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppid_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ppid_pkg::LIMIT_BITS-1:0]     cfg_data
);

	localparam int DIFF_BITS  = POS_BITS + 1;
	localparam int ENTRY_BITS = 3 * DIFF_BITS + 2 * TIME_BITS;

	// configuration registers
	logic [ID_BITS-1:0]              first_id_q;
	logic [ID_BITS-1:0]              second_id_q;
	logic [ppid_pkg::LIMIT_BITS-1:0] limit_q;

	// input field split
	logic                   accept;
	logic [ID_BITS-1:0]     object_id;
	logic [TIME_BITS-1:0]   sample_time;
	logic [POS_BITS-1:0]    pos_x, pos_y, pos_z;

	// queue between front and back
	logic                   req_push;
	logic [ENTRY_BITS-1:0]  req_push_data;
	logic                   queue_full;
	logic                   req_pop;
	logic                   req_valid;
	logic [ENTRY_BITS-1:0]  req_data;

	logic [2*TIME_BITS-1:0] result_data;

	assign cfg_ready = 1'b1;

	// unknown register indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_id_q  <= ID_BITS'(0);
			second_id_q <= ID_BITS'(1);
			limit_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ppid_pkg::REG_FIRST_ID:   first_id_q  <= cfg_data[ID_BITS-1:0];
				ppid_pkg::REG_SECOND_ID:  second_id_q <= cfg_data[ID_BITS-1:0];
				ppid_pkg::REG_DIST_LIMIT: limit_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// the front takes a sample whenever the queue has room
	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;

	assign object_id   = s_tdata[0 +: ID_BITS];
	assign sample_time = s_tdata[ID_BITS +: TIME_BITS];
	assign pos_x       = s_tdata[ID_BITS + TIME_BITS +: POS_BITS];
	assign pos_y       = s_tdata[ID_BITS + TIME_BITS + POS_BITS +: POS_BITS];
	assign pos_z       = s_tdata[ID_BITS + TIME_BITS + 2*POS_BITS +: POS_BITS];

	ppid_front #(
		.ID_BITS   (ID_BITS),
		.TIME_BITS (TIME_BITS),
		.POS_BITS  (POS_BITS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.object_id        (object_id),
		.sample_time      (sample_time),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.first_object_id  (first_id_q),
		.second_object_id (second_id_q),
		.req_push         (req_push),
		.req_data         (req_push_data)
	);

	ppid_queue #(
		.WIDTH      (ENTRY_BITS),
		.DEPTH_LOG2 (ppid_pkg::QUEUE_DEPTH_LOG2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_push),
		.push_data (req_push_data),
		.full      (queue_full),
		.pop       (req_pop),
		.not_empty (req_valid),
		.pop_data  (req_data)
	);

	ppid_back #(
		.TIME_BITS (TIME_BITS),
		.POS_BITS  (POS_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_data          (req_data),
		.req_pop           (req_pop),
		.distance_sq_limit (limit_q),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (result_data)
	);

	assign m_tdata = OUT_DATA_BITS'(result_data);

	// a request never lands in a full queue
	assert property (@(posedge clk) disable iff (!arst_n) req_push |-> !queue_full)
		else $error("request pushed into full queue");

	// nothing is taken from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) req_pop |-> req_valid)
		else $error("request popped from empty queue");

	// a reported interval never ends before it starts
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (result_data[2*TIME_BITS-1:TIME_BITS] >= result_data[TIME_BITS-1:0]))
		else $error("interval end before start");

endmodule

// File: rtl/ppid_queue.sv
// ----------------------------------------------------------------------------
// ppid_queue
// small request queue between the front and the back part
// ----------------------------------------------------------------------------
module ppid_queue #(
	parameter int WIDTH      = 8,
	parameter int DEPTH_LOG2 = ppid_pkg::QUEUE_DEPTH_LOG2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	localparam int DEPTH = 1 << DEPTH_LOG2;
	localparam logic [DEPTH_LOG2:0] DEPTH_CNT = (DEPTH_LOG2 + 1)'(DEPTH);

	logic [WIDTH-1:0]      mem_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wr_ptr_q;
	logic [DEPTH_LOG2-1:0] rd_ptr_q;
	logic [DEPTH_LOG2:0]   count_q;

	assign full      = (count_q == DEPTH_CNT);
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: rtl/ppid_front.sv
// ----------------------------------------------------------------------------
// ppid_front
// per-object sample tracking and distance request building
// ----------------------------------------------------------------------------
module ppid_front #(
	parameter int ID_BITS   = ppid_pkg::ID_BITS_DEF,
	parameter int TIME_BITS = ppid_pkg::TIME_BITS_DEF,
	parameter int POS_BITS  = ppid_pkg::POS_BITS_DEF,
	localparam int DIFF_BITS  = POS_BITS + 1,
	localparam int ENTRY_BITS = 3 * DIFF_BITS + 2 * TIME_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [ID_BITS-1:0]    object_id,
	input  logic [TIME_BITS-1:0]  sample_time,
	input  logic [POS_BITS-1:0]   pos_x,
	input  logic [POS_BITS-1:0]   pos_y,
	input  logic [POS_BITS-1:0]   pos_z,
	input  logic [ID_BITS-1:0]    first_object_id,
	input  logic [ID_BITS-1:0]    second_object_id,
	output logic                  req_push,
	output logic [ENTRY_BITS-1:0] req_data
);

	logic                 seen_first_q, seen_second_q;
	logic [TIME_BITS-1:0] first_now_q, first_before_q;
	logic [TIME_BITS-1:0] second_now_q, second_before_q;
	logic [POS_BITS-1:0]  first_pos_q [3];
	logic [POS_BITS-1:0]  second_pos_q [3];

	logic                 hit_first, hit_second;
	logic                 seen_first_d, seen_second_d;
	logic [TIME_BITS-1:0] first_now_d, first_before_d;
	logic [TIME_BITS-1:0] second_now_d, second_before_d;
	logic [POS_BITS-1:0]  in_pos [3];
	logic [POS_BITS-1:0]  first_pos_d [3];
	logic [POS_BITS-1:0]  second_pos_d [3];
	logic [DIFF_BITS-1:0] diff [3];
	logic [TIME_BITS-1:0] now_max, before_min;

	assign hit_first  = (object_id == first_object_id);
	assign hit_second = !hit_first && (object_id == second_object_id);

	assign in_pos[0] = pos_x;
	assign in_pos[1] = pos_y;
	assign in_pos[2] = pos_z;

	always_comb begin
		seen_first_d    = seen_first_q | hit_first;
		seen_second_d   = seen_second_q | hit_second;
		first_now_d     = hit_first ? sample_time : first_now_q;
		first_before_d  = hit_first ? first_now_q : first_before_q;
		second_now_d    = hit_second ? sample_time : second_now_q;
		second_before_d = hit_second ? second_now_q : second_before_q;
		for (int i = 0; i < 3; i++) begin
			first_pos_d[i]  = hit_first ? in_pos[i] : first_pos_q[i];
			second_pos_d[i] = hit_second ? in_pos[i] : second_pos_q[i];
			diff[i] = {first_pos_d[i][POS_BITS-1], first_pos_d[i]}
				- {second_pos_d[i][POS_BITS-1], second_pos_d[i]};
		end
		now_max    = (first_now_d > second_now_d) ? first_now_d : second_now_d;
		before_min = (first_before_d < second_before_d) ? first_before_d : second_before_d;
	end

	// only a tracked sample with both objects known asks for a comparison
	assign req_push = accept && (hit_first || hit_second) && seen_first_d && seen_second_d;
	assign req_data = {before_min, now_max, diff[2], diff[1], diff[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_first_q    <= 1'b0;
			seen_second_q   <= 1'b0;
			first_now_q     <= '0;
			first_before_q  <= '0;
			second_now_q    <= '0;
			second_before_q <= '0;
		end else if (accept) begin
			seen_first_q    <= seen_first_d;
			seen_second_q   <= seen_second_d;
			first_now_q     <= first_now_d;
			first_before_q  <= first_before_d;
			second_now_q    <= second_now_d;
			second_before_q <= second_before_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				first_pos_q[i]  <= first_pos_d[i];
				second_pos_q[i] <= second_pos_d[i];
			end
		end
	end

endmodule

// File: rtl/ppid_back.sv
// ----------------------------------------------------------------------------
// ppid_back
// squared distance, threshold compare and interval tracking
// ----------------------------------------------------------------------------
module ppid_back #(
	parameter int TIME_BITS = ppid_pkg::TIME_BITS_DEF,
	parameter int POS_BITS  = ppid_pkg::POS_BITS_DEF,
	localparam int DIFF_BITS  = POS_BITS + 1,
	localparam int ENTRY_BITS = 3 * DIFF_BITS + 2 * TIME_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic [ENTRY_BITS-1:0]           req_data,
	output logic                            req_pop,
	input  logic [ppid_pkg::LIMIT_BITS-1:0] distance_sq_limit,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [2*TIME_BITS-1:0]          m_tdata
);

	localparam int SQ_BITS  = 2 * POS_BITS;
	localparam int SUM_BITS = SQ_BITS + 2;
	localparam int CMP_BITS = (SUM_BITS > ppid_pkg::LIMIT_BITS) ? SUM_BITS
		: ppid_pkg::LIMIT_BITS;

	logic                           back_en;
	logic signed [DIFF_BITS-1:0]    diff [3];
	logic signed [2*DIFF_BITS-1:0]  prod [3];
	logic [TIME_BITS-1:0]           now_max, before_min;

	logic                 valid_s1;
	logic [SQ_BITS-1:0]   sq_s1 [3];
	logic [TIME_BITS-1:0] now_max_s1, before_min_s1;

	logic                 open_q;
	logic [TIME_BITS-1:0] start_q;
	logic                 out_valid_q;
	logic [TIME_BITS-1:0] out_start_q, out_end_q;

	logic [SUM_BITS-1:0]  dist_sum;
	logic                 close;
	logic                 emit;

	assign back_en = !out_valid_q || m_tready;
	assign req_pop = back_en && req_valid;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = signed'(req_data[i*DIFF_BITS +: DIFF_BITS]);
			prod[i] = diff[i] * diff[i];
		end
	end
	assign now_max    = req_data[3*DIFF_BITS +: TIME_BITS];
	assign before_min = req_data[3*DIFF_BITS + TIME_BITS +: TIME_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (back_en)
			valid_s1 <= req_valid;
	end

	// |diff| stays below 2**POS_BITS, so the square fits SQ_BITS
	always_ff @(posedge clk) begin
		if (back_en) begin
			for (int i = 0; i < 3; i++)
				sq_s1[i] <= prod[i][SQ_BITS-1:0];
			now_max_s1    <= now_max;
			before_min_s1 <= before_min;
		end
	end

	assign dist_sum = {2'b00, sq_s1[0]} + {2'b00, sq_s1[1]} + {2'b00, sq_s1[2]};
	assign close    = CMP_BITS'(dist_sum) <= CMP_BITS'(distance_sq_limit);
	assign emit     = valid_s1 && !close && open_q && (before_min_s1 >= start_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (back_en) begin
			out_valid_q <= emit;
			if (valid_s1) begin
				if (close) begin
					if (!open_q) begin
						open_q  <= 1'b1;
						start_q <= now_max_s1;
					end
				end else begin
					open_q  <= 1'b0;
					start_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (back_en && emit) begin
			out_start_q <= start_q;
			out_end_q   <= before_min_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_end_q, out_start_q};

endmodule

// File: tb/pair_proximity_interval_detector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pair_proximity_interval_detector_core_tb
// self-checking bench for the pair proximity interval detector
// ----------------------------------------------------------------------------
// Streams tagged position samples into the core and predicts each reported
// interval with a cycle-free model of the two tracked objects. Directed tests
// cover reset values, field extremes and the corner cases of interval
// bookkeeping. A long output hold fills the request queue. Random phases under
// several register settings follow. Both ports idle in random bursts except
// in the long output hold test and in the final phase.
// ----------------------------------------------------------------------------
module pair_proximity_interval_detector_core_tb;

	// register indexes that decode to nothing
	localparam logic [ppid_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED_LO = 8'd3;
	localparam logic [ppid_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED_HI = 8'hFF;

	localparam logic [ppid_pkg::LIMIT_BITS-1:0] LIMIT_MAX = {ppid_pkg::LIMIT_BITS{1'b1}};

	// cycles the block may still be busy after the last reported interval
	localparam int DRAIN_CYCLES = 12;
	// length of the long output hold
	localparam int HOLD_CYCLES  = 80;

	typedef struct {
		logic [31:0] t_open;
		logic [31:0] t_close;
	} interval_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// object_id, sample_time, pos_x, pos_y, pos_z
	logic [119:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// interval_start, interval_end
	logic [63:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [ppid_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [ppid_pkg::LIMIT_BITS-1:0]     cfg_data;

	pair_proximity_interval_detector_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register copies held by the bench
	logic [15:0]                     cfg_id_a;
	logic [15:0]                     cfg_id_b;
	logic [ppid_pkg::LIMIT_BITS-1:0] cfg_limit;

	// per-object tracking state of the predictor
	logic               a_seen, b_seen;
	logic [31:0]        a_now, a_prev, b_now, b_prev;
	logic signed [23:0] a_pos [3];
	logic signed [23:0] b_pos [3];
	logic               prox_open;
	logic [31:0]        prox_start;

	interval_t pending_intervals [$];

	int  errors;
	int  samples_sent;
	int  intervals_checked;
	int  reg_writes;
	bit  idle_enabled;
	bit  hold_request;
	int  hold_left;
	int  stall_left;

	// clock, 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	// predictor: updates the tracked pair on one sample, returns 1 when an
	// interval is reported
	function automatic bit track_pair_sample(input logic [15:0] id, input logic [31:0] ts,
			input logic signed [23:0] px, input logic signed [23:0] py,
			input logic signed [23:0] pz, output interval_t iv);
		longint signed      d;
		longint unsigned    dist_sum;
		logic [31:0]        closing;
		logic signed [23:0] p [3];
		bit                 emit;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		iv.t_open  = '0;
		iv.t_close = '0;
		// first register wins when both hold the same id
		if (id == cfg_id_a) begin
			a_prev = a_now;
			a_now  = ts;
			for (int i = 0; i < 3; i++) a_pos[i] = p[i];
			a_seen = 1'b1;
		end else if (id == cfg_id_b) begin
			b_prev = b_now;
			b_now  = ts;
			for (int i = 0; i < 3; i++) b_pos[i] = p[i];
			b_seen = 1'b1;
		end else begin
			return 1'b0;
		end
		if (!(a_seen && b_seen))
			return 1'b0;
		dist_sum = 0;
		for (int i = 0; i < 3; i++) begin
			d = longint'(a_pos[i]) - longint'(b_pos[i]);
			dist_sum += longint'(d * d);
		end
		if (dist_sum <= longint'({12'b0, cfg_limit})) begin
			// a close sample keeps an interval that is already open
			if (!prox_open) begin
				prox_open  = 1'b1;
				prox_start = (a_now > b_now) ? a_now : b_now;
			end
			return 1'b0;
		end
		closing    = (a_prev < b_prev) ? a_prev : b_prev;
		emit       = prox_open && (closing >= prox_start);
		iv.t_open  = prox_start;
		iv.t_close = closing;
		prox_open  = 1'b0;
		prox_start = '0;
		return emit;
	endfunction

	// one sample request; entered and left at a falling edge
	task automatic send_sample(input logic [15:0] id, input logic [31:0] ts,
			input logic signed [23:0] px, input logic signed [23:0] py,
			input logic signed [23:0] pz);
		interval_t iv;
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {pz, py, px, ts, id};
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		if (track_pair_sample(id, ts, px, py, pz, iv))
			pending_intervals.insert(pending_intervals.size(), iv);
		@(negedge clk);
	endtask

	// register write, issued only once the block has gone quiet
	task automatic write_reg(input logic [ppid_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [ppid_pkg::LIMIT_BITS-1:0] value);
		s_tvalid = 1'b0;
		while (pending_intervals.size() != 0) @(negedge clk);
		// samples that report nothing may still be in the pipe
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (idx)
			ppid_pkg::REG_FIRST_ID:   cfg_id_a  = value[15:0];
			ppid_pkg::REG_SECOND_ID:  cfg_id_b  = value[15:0];
			ppid_pkg::REG_DIST_LIMIT: cfg_limit = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// result checker, compares each accepted interval with the oldest prediction
	always @(posedge clk) begin : check_results
		interval_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_intervals.size() == 0) begin
				report_mismatch("unexpected interval start", m_tdata[31:0], 32'h0);
			end else begin
				want = pending_intervals.pop_front();
				intervals_checked++;
				if (m_tdata[31:0] !== want.t_open)
					report_mismatch("interval_start", m_tdata[31:0], want.t_open);
				if (m_tdata[63:32] !== want.t_close)
					report_mismatch("interval_end", m_tdata[63:32], want.t_close);
			end
		end
	end

	// receiver: random stall bursts plus one long hold on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (!arst_n) begin
			m_tready = 1'b0;
		end else if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
			m_tready   = 1'b0;
			stall_left = $urandom_range(1, 11) - 1;
		end else begin
			m_tready = 1'b1;
		end
	end

	// registers at reset values, untracked id, open, keep, end-before-start, report
	task automatic test_default_registers();
		send_sample(16'd0, 32'd10, 24'sd1, 24'sd2, 24'sd3);
		send_sample(16'd7, 32'd11, 24'sd5, 24'sd5, 24'sd5);
		send_sample(16'd1, 32'd12, 24'sd1, 24'sd2, 24'sd3);
		send_sample(16'd0, 32'd20, 24'sd1, 24'sd2, 24'sd3);
		send_sample(16'd1, 32'd30, 24'sd1, 24'sd2, 24'sd4);
		send_sample(16'd1, 32'd40, 24'sd1, 24'sd2, 24'sd3);
		send_sample(16'd0, 32'd50, 24'sd1, 24'sd2, 24'sd3);
		send_sample(16'd1, 32'd60, 24'sd1, 24'sd2, 24'sd3);
		send_sample(16'd0, 32'd70, 24'sd9, 24'sd2, 24'sd3);
	endtask

	// full-scale ids, times, positions and limits; upper register bits ignored
	task automatic test_field_extremes();
		write_reg(ppid_pkg::REG_FIRST_ID,   52'hF_1234_5678_FFFF);
		write_reg(ppid_pkg::REG_SECOND_ID,  52'hA_BCDE_F000_0000);
		write_reg(ppid_pkg::REG_DIST_LIMIT, LIMIT_MAX);
		send_sample(16'hFFFF, 32'h0, -24'sd8388608, -24'sd8388608, -24'sd8388608);
		send_sample(16'h0000, 32'hFFFF_FFFF, 24'sd8388607, 24'sd8388607, 24'sd8388607);
		send_sample(16'hFFFF, 32'hFFFF_FFFF, 24'sd8388607, -24'sd8388608, 24'sd0);
		write_reg(ppid_pkg::REG_DIST_LIMIT, '0);
		send_sample(16'h0000, 32'hFFFF_FFFF, -24'sd8388608, 24'sd8388607, 24'sd8388607);
		send_sample(16'hFFFF, 32'hFFFF_FFFF, -24'sd8388608, 24'sd8388607, 24'sd8388607);
		send_sample(16'h0000, 32'hFFFF_FFFF, -24'sd8388608, 24'sd8388607, 24'sd8388607);
		send_sample(16'hFFFF, 32'hFFFF_FFFF, 24'sd8388607, 24'sd8388607, 24'sd8388607);
	endtask

	// shared id, never-written previous time, separation while closed,
	// distance equal to the limit, unknown register indexes
	task automatic test_special_cases();
		write_reg(ppid_pkg::REG_FIRST_ID,   52'h00A5);
		write_reg(ppid_pkg::REG_SECOND_ID,  52'h00A5);
		write_reg(ppid_pkg::REG_DIST_LIMIT, 52'd100);
		write_reg(REG_UNUSED_LO,  52'h5A);
		write_reg(REG_UNUSED_HI,  LIMIT_MAX);
		send_sample(16'h00A5, 32'd100, 24'sd0, 24'sd0, 24'sd0);
		send_sample(16'h00A5, 32'd105, 24'sd0, 24'sd0, 24'sd0);
		write_reg(ppid_pkg::REG_SECOND_ID,  52'h005A);
		send_sample(16'h005A, 32'd110, 24'sd3, 24'sd4, 24'sd0);
		send_sample(16'h00A5, 32'd120, 24'sd0, 24'sd0, 24'sd0);
		send_sample(16'h005A, 32'd130, 24'sd0, 24'sd0, 24'sd11);
		send_sample(16'h00A5, 32'd140, 24'sd0, 24'sd0, 24'sd0);
		send_sample(16'h005A, 32'd200, 24'sd6, 24'sd8, 24'sd0);
		send_sample(16'h00A5, 32'd210, 24'sd0, 24'sd0, 24'sd0);
		send_sample(16'h00A5, 32'd230, 24'sd0, 24'sd0, 24'sd1);
	endtask

	// output held off for a long stretch while samples keep coming
	task automatic test_backpressure();
		write_reg(ppid_pkg::REG_FIRST_ID,   52'd3);
		write_reg(ppid_pkg::REG_SECOND_ID,  52'd4);
		write_reg(ppid_pkg::REG_DIST_LIMIT, 52'd16);
		idle_enabled = 1'b0;
		hold_request = 1'b1;
		for (int j = 0; j < 48; j++) begin
			if (j % 2 == 0)
				send_sample(16'd3, 32'(j * 5), 24'sd0, 24'sd0, 24'sd0);
			else if (j % 6 == 5)
				send_sample(16'd4, 32'(j * 5), 24'sd0, 24'sd0, 24'sd100);
			else
				send_sample(16'd4, 32'(j * 5), 24'sd0, 24'sd0, 24'sd1);
		end
		idle_enabled = 1'b1;
	endtask

	// random phases: mostly paired samples that drift between near and far
	task automatic test_random_phases();
		int  count, r, cx, cy, cz, vx, vy, vz, sgn;
		int  pick;
		bit  near;
		logic [15:0] id, id_a, id_b;
		logic [31:0] clock_t;
		logic [ppid_pkg::LIMIT_BITS-1:0] lim;
		near    = 1'b1;
		clock_t = $urandom;
		cx = 0;
		cy = 0;
		cz = 0;
		for (int ph = 0; ph < 6; ph++) begin
			id_a  = $urandom;
			id_b  = $urandom;
			r     = $urandom_range(1, 1 << 16);
			count = 260;
			case (ph)
				1: r = 0;
				2: r = $urandom_range(1 << 18, 1 << 20);
				3: begin
					id_b  = id_a;
					count = 100;
				end
				4: begin
					id_a = 16'h0000;
					id_b = 16'hFFFF;
				end
				5: idle_enabled = 1'b0;
				default: ;
			endcase
			if (id_b == id_a && ph != 3) id_b = id_a + 16'd1;
			lim = (ph == 2) ? LIMIT_MAX
				: ppid_pkg::LIMIT_BITS'(longint'(r) * longint'(r));
			write_reg(ppid_pkg::REG_FIRST_ID,   {$urandom, 4'h0, id_a} );
			write_reg(ppid_pkg::REG_SECOND_ID,  52'(id_b));
			write_reg(ppid_pkg::REG_DIST_LIMIT, lim);
			if (ph == 0) write_reg(REG_UNUSED_LO, 52'(id_a));
			for (int n = 0; n < count; n++) begin
				if ($urandom_range(0, 7) == 0) near = !near;
				// occasional jumps, forward or backward
				if ($urandom_range(0, 49) == 0) clock_t = $urandom;
				else clock_t += $urandom_range(0, 6);
				if ($urandom_range(0, 99) == 0) begin
					cx = int'($urandom_range(0, 1 << 23)) - (1 << 22);
					cy = int'($urandom_range(0, 1 << 23)) - (1 << 22);
					cz = int'($urandom_range(0, 1 << 23)) - (1 << 22);
				end
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// untracked id with arbitrary content
					id = $urandom;
					vx = $urandom;
					vy = $urandom;
					vz = $urandom;
				end else if (pick % 2 == 1) begin
					id = cfg_id_a;
					vx = cx;
					vy = cy;
					vz = cz;
				end else begin
					id = cfg_id_b;
					if (near) begin
						vx = cx + int'($urandom_range(0, r)) - r / 2;
						vy = cy + int'($urandom_range(0, r)) - r / 2;
						vz = cz + int'($urandom_range(0, r)) - r / 2;
					end else begin
						sgn = ($urandom_range(0, 1) == 0) ? 1 : -1;
						vx = cx + sgn * (r + int'($urandom_range(1, 1 << 20)));
						vy = cy + int'($urandom_range(0, r)) - r / 2;
						vz = cz;
					end
				end
				// noisy tracked samples anywhere in the field
				if (pick >= 8 && pick < 13) begin
					vx = $urandom;
					vy = $urandom;
					vz = $urandom;
				end
				send_sample(id, clock_t, vx[23:0], vy[23:0], vz[23:0]);
			end
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		errors       = 0;
		samples_sent = 0;
		intervals_checked = 0;
		reg_writes   = 0;
		idle_enabled = 1'b1;
		hold_request = 1'b0;
		hold_left    = 0;
		stall_left   = 0;
		// predictor and register copies at their reset values
		cfg_id_a   = 16'd0;
		cfg_id_b   = 16'd1;
		cfg_limit  = '0;
		a_seen     = 1'b0;
		b_seen     = 1'b0;
		a_now      = '0;
		a_prev     = '0;
		b_now      = '0;
		b_prev     = '0;
		prox_open  = 1'b0;
		prox_start = '0;
		for (int i = 0; i < 3; i++) begin
			a_pos[i] = '0;
			b_pos[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_registers();
		test_field_extremes();
		test_special_cases();
		test_backpressure();
		test_random_phases();

		// wait for the last intervals, then for any stray output
		s_tvalid = 1'b0;
		while (pending_intervals.size() != 0) @(posedge clk);
		repeat (4 * DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples under %0d register writes, %0d intervals checked",
			samples_sent, reg_writes, intervals_checked);
		$display("with output stalls, a long hold-off and a final phase at full rate");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/ppid_pkg.sv
rtl/ppid_queue.sv
rtl/ppid_front.sv
rtl/ppid_back.sv
rtl/pair_proximity_interval_detector_core.sv
tb/pair_proximity_interval_detector_core_tb.sv
